@@ rtl/bas_pkg.sv @@
// ----------------------------------------------------------------------------
// Battery alert package
// Shared types, widths and register codes for the battery alert unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bas_pkg;

    localparam int PCT_W   = 7;
    localparam int HOURS_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PCT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_PCT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HOURS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADROOM     = 2'd3;

    localparam logic [PCT_W-1:0]   RST_FIRST_PCT    = 7'd20;
    localparam logic [PCT_W-1:0]   RST_SECOND_PCT   = 7'd13;
    localparam logic [HOURS_W-1:0] RST_SECOND_HOURS = 8'd12;
    localparam logic [HOURS_W-1:0] RST_HEADROOM     = 8'd3;

    localparam logic [PCT_W-1:0] FULL_PERCENT = 7'd100;

    typedef struct packed {
        logic [PCT_W-1:0]   first_warning_percent;
        logic [PCT_W-1:0]   second_warning_percent;
        logic [HOURS_W-1:0] second_point_hours;
        logic [HOURS_W-1:0] headroom_hours;
    } cfg_t;

    typedef struct packed {
        logic               req_type;
        logic               chg_ind;
        logic               cable_in;
        logic [PCT_W-1:0]   gauge_percent;
        logic [PCT_W-1:0]   batt_pct;
        logic               critical_lockout;
        logic               low_power_active;
        logic [HOURS_W-1:0] hours_left;
        logic               dnd_active;
    } evt_t;

    typedef struct packed {
        logic [2:0]       ui_state;
        logic             accepted;
        logic [1:0]       exit_action;
        logic [2:0]       enter_action;
        logic             show_warning;
        logic             warning_level;
        logic [PCT_W-1:0] warning_percent;
        logic             vibrate;
        logic             standby_request;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/bas_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Battery alert configuration registers
// Warning thresholds and hour limits, written through the config channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bas_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bas_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bas_pkg::CFG_DATA_W-1:0]   cfg_data,
    output bas_pkg::cfg_t                         cfg
);

    bas_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_warning_percent  <= bas_pkg::RST_FIRST_PCT;
            cfg_reg.second_warning_percent <= bas_pkg::RST_SECOND_PCT;
            cfg_reg.second_point_hours     <= bas_pkg::RST_SECOND_HOURS;
            cfg_reg.headroom_hours         <= bas_pkg::RST_HEADROOM;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bas_pkg::CFG_FIRST_PCT:
                    cfg_reg.first_warning_percent <= cfg_data[bas_pkg::PCT_W-1:0];
                bas_pkg::CFG_SECOND_PCT:
                    cfg_reg.second_warning_percent <= cfg_data[bas_pkg::PCT_W-1:0];
                bas_pkg::CFG_SECOND_HOURS:
                    cfg_reg.second_point_hours <= cfg_data;
                bas_pkg::CFG_HEADROOM:
                    cfg_reg.headroom_hours <= cfg_data;
                default:
                    cfg_reg.headroom_hours <= cfg_reg.headroom_hours;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/bas_core.sv @@
// ----------------------------------------------------------------------------
// Battery alert core
// Classifies one event, applies the transition table, tracks the warning
// level and registers the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module bas_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          evt_valid,
    input  wire bas_pkg::evt_t evt,
    input  wire bas_pkg::cfg_t cfg,
    output logic               take,
    output logic               res_valid,
    input  wire logic          res_stall,
    output bas_pkg::res_t      res
);

    typedef enum logic [2:0] {
        ST_GOOD         = 3'd1,
        ST_WARNING      = 3'd2,
        ST_LOW_POWER    = 3'd3,
        ST_CRITICAL     = 3'd4,
        ST_CHARGING     = 3'd5,
        ST_FULL         = 3'd6,
        ST_SHUTDOWN_CHG = 3'd7
    } state_t;

    localparam logic [1:0] WIDX_FIRST  = 2'd0;
    localparam logic [1:0] WIDX_SECOND = 2'd1;
    localparam logic [1:0] WIDX_NONE   = 2'd3;

    localparam logic [1:0] EXIT_NONE      = 2'd0;
    localparam logic [1:0] EXIT_DISMISS   = 2'd1;
    localparam logic [1:0] EXIT_LOW_POWER = 2'd2;
    localparam logic [1:0] EXIT_CRITICAL  = 2'd3;

    localparam logic [2:0] ENTER_NONE      = 3'd0;
    localparam logic [2:0] ENTER_LOW_POWER = 3'd1;
    localparam logic [2:0] ENTER_CRITICAL  = 3'd2;
    localparam logic [2:0] ENTER_PLUGGED   = 3'd3;
    localparam logic [2:0] ENTER_FULL      = 3'd4;
    localparam logic [2:0] ENTER_SHUTDOWN  = 3'd5;

    localparam logic [7:0] ALLOW_GOOD      = 8'h7C;
    localparam logic [7:0] ALLOW_WARNING   = 8'h2E;
    localparam logic [7:0] ALLOW_LOW_POWER = 8'h34;
    localparam logic [7:0] ALLOW_CRITICAL  = 8'h28;
    localparam logic [7:0] ALLOW_CHARGING  = 8'hDE;
    localparam logic [7:0] ALLOW_FULL      = 8'h9E;
    localparam logic [7:0] ALLOW_NONE      = 8'h00;

    state_t        state_reg, state_next;
    logic [1:0]    widx_reg, widx_next;
    logic          res_valid_reg;
    bas_pkg::res_t res_reg, res_next;

    state_t     target;
    state_t     classified;
    logic [7:0] allow_mask;
    logic       go;
    logic [1:0] widx_w;
    logic       fresh;
    logic [8:0] hours_limit;
    logic       hours_short;

    assign take      = evt_valid && (!res_valid_reg || !res_stall);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign hours_limit = {1'b0, cfg.second_point_hours} + {1'b0, cfg.headroom_hours};
    assign hours_short = {1'b0, evt.hours_left} < hours_limit;

    always_comb
    begin
        if (evt.chg_ind)
            classified = ST_CHARGING;
        else if (evt.cable_in && evt.gauge_percent >= bas_pkg::FULL_PERCENT)
            classified = ST_FULL;
        else if (evt.critical_lockout)
            classified = ST_CRITICAL;
        else if (evt.low_power_active)
            classified = ST_LOW_POWER;
        else if (evt.batt_pct <= cfg.first_warning_percent)
            classified = ST_WARNING;
        else
            classified = ST_GOOD;
    end

    always_comb
    begin
        unique case (state_reg)
            ST_GOOD:      allow_mask = ALLOW_GOOD;
            ST_WARNING:   allow_mask = ALLOW_WARNING;
            ST_LOW_POWER: allow_mask = ALLOW_LOW_POWER;
            ST_CRITICAL:  allow_mask = ALLOW_CRITICAL;
            ST_CHARGING:  allow_mask = ALLOW_CHARGING;
            ST_FULL:      allow_mask = ALLOW_FULL;
            default:      allow_mask = ALLOW_NONE;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        widx_next  = widx_reg;
        res_next   = '0;
        go         = 1'b0;
        target     = classified;
        widx_w     = widx_reg;
        fresh      = 1'b0;

        if (evt.req_type)
        begin
            target = ST_SHUTDOWN_CHG;
            if (state_reg == ST_CHARGING)
                go = 1'b1;
            else
                res_next.standby_request = 1'b1;
        end
        else
        begin
            go = allow_mask[target];
        end

        if (go)
        begin
            if (state_reg != target)
            begin
                unique case (state_reg) inside
                    ST_WARNING, ST_CHARGING, ST_FULL: res_next.exit_action = EXIT_DISMISS;
                    ST_LOW_POWER:                     res_next.exit_action = EXIT_LOW_POWER;
                    ST_CRITICAL:                      res_next.exit_action = EXIT_CRITICAL;
                    default:                          res_next.exit_action = EXIT_NONE;
                endcase
                if (state_reg == ST_WARNING)
                    widx_next = WIDX_NONE;
                state_next = target;
            end
            res_next.accepted = 1'b1;

            unique case (target)
                ST_WARNING:
                begin
                    res_next.enter_action = ENTER_NONE;
                    widx_w = widx_next;
                    if (widx_w == WIDX_NONE && evt.batt_pct <= cfg.first_warning_percent)
                    begin
                        widx_w = WIDX_FIRST;
                        fresh  = 1'b1;
                    end
                    if (widx_w == WIDX_FIRST && evt.batt_pct <= cfg.second_warning_percent)
                    begin
                        widx_w = WIDX_SECOND;
                        fresh  = 1'b1;
                    end
                    if (fresh && widx_w == WIDX_FIRST && hours_short)
                        fresh = 1'b0;
                    widx_next = widx_w;
                    if (fresh)
                    begin
                        res_next.show_warning    = 1'b1;
                        res_next.warning_level   = widx_w[0];
                        res_next.warning_percent = evt.batt_pct;
                        res_next.vibrate         = !evt.dnd_active;
                    end
                end
                ST_LOW_POWER:
                    res_next.enter_action = ENTER_LOW_POWER;
                ST_CRITICAL:
                begin
                    res_next.enter_action = ENTER_CRITICAL;
                    res_next.vibrate      = !evt.dnd_active;
                end
                ST_CHARGING:
                begin
                    res_next.enter_action = ENTER_PLUGGED;
                    res_next.vibrate      = !evt.dnd_active;
                end
                ST_FULL:
                    res_next.enter_action = ENTER_FULL;
                ST_SHUTDOWN_CHG:
                begin
                    res_next.enter_action    = ENTER_SHUTDOWN;
                    res_next.standby_request = 1'b1;
                end
                default:
                    res_next.enter_action = ENTER_NONE;
            endcase
        end

        res_next.ui_state = state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_GOOD;
            widx_reg      <= WIDX_NONE;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else if (take)
        begin
            state_reg     <= state_next;
            widx_reg      <= widx_next;
            res_valid_reg <= 1'b1;
            res_reg       <= res_next;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    a_shutdown_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHUTDOWN_CHG) |=> (state_reg == ST_SHUTDOWN_CHG))
        else $error("left shutdown charging without reset");

    a_widx_only_in_warning: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_WARNING) |-> (widx_reg == WIDX_NONE))
        else $error("warning level held outside warning state");

    a_reject_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !res_next.accepted) |=> $stable(state_reg) && $stable(widx_reg))
        else $error("rejected event changed state");

    a_warning_shown_in_warning: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.show_warning) |-> (res_reg.ui_state == ST_WARNING))
        else $error("warning shown outside warning state");

endmodule

`default_nettype wire

@@ rtl/battery_alert_state_machine_unit.sv @@
// ----------------------------------------------------------------------------
// Battery alert state machine unit
// Turns charge events and shutdown requests into UI state changes, warnings,
// vibration and standby requests.
//
//   channel  | handshake            | word
//   ---------+----------------------+--------------------------------------
//   evt      | evt_valid/evt_stall  | one charge event or shutdown request
//   res      | res_valid/res_stall  | one result per event
//   cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data register write
//
// One event per cycle without res_stall; input register, then result register.
// The state update sits in the single step between those registers.
// Reset restores the default thresholds, the good state and no warning level.
// A stalled result holds; evt_stall rises only when both registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_alert_state_machine_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               evt_valid,
    output logic                                    evt_stall,
    input  wire logic                               req_type,
    input  wire logic                               chg_ind,
    input  wire logic                               cable_in,
    input  wire logic [bas_pkg::PCT_W-1:0]          gauge_percent,
    input  wire logic [bas_pkg::PCT_W-1:0]          batt_pct,
    input  wire logic                               critical_lockout,
    input  wire logic                               low_power_active,
    input  wire logic [bas_pkg::HOURS_W-1:0]        hours_left,
    input  wire logic                               dnd_active,

    output logic                                    res_valid,
    input  wire logic                               res_stall,
    output logic [2:0]                              ui_state,
    output logic                                    accepted,
    output logic [1:0]                              exit_action,
    output logic [2:0]                              enter_action,
    output logic                                    show_warning,
    output logic                                    warning_level,
    output logic [bas_pkg::PCT_W-1:0]               warning_percent,
    output logic                                    vibrate,
    output logic                                    standby_request,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [bas_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bas_pkg::CFG_DATA_W-1:0]     cfg_data
);

    bas_pkg::cfg_t cfg;
    bas_pkg::evt_t evt_reg;
    bas_pkg::res_t res;
    logic          evt_valid_reg;
    logic          take;

    assign evt_stall = evt_valid_reg && !take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            evt_valid_reg <= 1'b0;
        else if (evt_valid && !evt_stall)
            evt_valid_reg <= 1'b1;
        else if (take)
            evt_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (evt_valid && !evt_stall)
        begin
            evt_reg.req_type         <= req_type;
            evt_reg.chg_ind          <= chg_ind;
            evt_reg.cable_in         <= cable_in;
            evt_reg.gauge_percent    <= gauge_percent;
            evt_reg.batt_pct         <= batt_pct;
            evt_reg.critical_lockout <= critical_lockout;
            evt_reg.low_power_active <= low_power_active;
            evt_reg.hours_left       <= hours_left;
            evt_reg.dnd_active       <= dnd_active;
        end
    end

    bas_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bas_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid_reg),
        .evt       (evt_reg),
        .cfg       (cfg),
        .take      (take),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    assign ui_state        = res.ui_state;
    assign accepted        = res.accepted;
    assign exit_action     = res.exit_action;
    assign enter_action    = res.enter_action;
    assign show_warning    = res.show_warning;
    assign warning_level   = res.warning_level;
    assign warning_percent = res.warning_percent;
    assign vibrate         = res.vibrate;
    assign standby_request = res.standby_request;

endmodule

`default_nettype wire

@@ verif/battery_alert_checker.sv @@
// ----------------------------------------------------------------------------
// Battery alert checker
// Watches the event, result and register write channels of the battery alert
// unit. Keeps its own model of the UI state, the warning level and the
// thresholds, predicts one result word per accepted event, and compares each
// accepted result word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

package bas_tb_pkg;

    typedef enum logic [2:0] {
        ST_NONE         = 3'd0,
        ST_GOOD         = 3'd1,
        ST_WARNING      = 3'd2,
        ST_LOW_POWER    = 3'd3,
        ST_CRITICAL     = 3'd4,
        ST_CHARGING     = 3'd5,
        ST_FULL         = 3'd6,
        ST_SHUTDOWN_CHG = 3'd7
    } ui_state_e;

    localparam logic REQ_EVENT    = 1'b0;
    localparam logic REQ_SHUTDOWN = 1'b1;

endpackage

module battery_alert_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               evt_valid,
    input  wire logic                               evt_stall,
    input  wire bas_pkg::evt_t                      evt,

    input  wire logic                               res_valid,
    input  wire logic                               res_stall,
    input  wire logic [2:0]                         ui_state,
    input  wire logic                               accepted,
    input  wire logic [1:0]                         exit_action,
    input  wire logic [2:0]                         enter_action,
    input  wire logic                               show_warning,
    input  wire logic                               warning_level,
    input  wire logic [bas_pkg::PCT_W-1:0]          warning_percent,
    input  wire logic                               vibrate,
    input  wire logic                               standby_request,

    input  wire logic                               cfg_valid,
    input  wire logic                               cfg_ready,
    input  wire logic [bas_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bas_pkg::CFG_DATA_W-1:0]     cfg_data,

    output int                                      error_count,
    output int                                      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import bas_pkg::*;
    import bas_tb_pkg::*;

    localparam logic [1:0] EXIT_NONE          = 2'd0;
    localparam logic [1:0] EXIT_DISMISS_MODAL = 2'd1;
    localparam logic [1:0] EXIT_LOW_POWER     = 2'd2;
    localparam logic [1:0] EXIT_CRITICAL      = 2'd3;

    localparam logic [2:0] ENTER_NONE      = 3'd0;
    localparam logic [2:0] ENTER_LOW_POWER = 3'd1;
    localparam logic [2:0] ENTER_CRITICAL  = 3'd2;
    localparam logic [2:0] ENTER_PLUGGED   = 3'd3;
    localparam logic [2:0] ENTER_FULL      = 3'd4;
    localparam logic [2:0] ENTER_SHUTDOWN  = 3'd5;

    localparam logic [1:0] LEVEL_FIRST  = 2'd0;
    localparam logic [1:0] LEVEL_SECOND = 2'd1;
    localparam logic [1:0] NO_WARNING   = 2'd3;

    logic [PCT_W-1:0]   first_pct;
    logic [PCT_W-1:0]   second_pct;
    logic [HOURS_W-1:0] second_hours;
    logic [HOURS_W-1:0] headroom;
    ui_state_e          ui_now;
    logic [1:0]         warn_idx;
    res_t               alert_q[$];
    res_t               want;

    function automatic res_t next_alert(evt_t ev);
        res_t      r;
        ui_state_e target;
        logic      go;
        logic      fresh;
        r     = '0;
        go    = 1'b0;
        fresh = 1'b0;
        if (ev.req_type == REQ_SHUTDOWN) begin
            target            = ST_SHUTDOWN_CHG;
            go                = (ui_now == ST_CHARGING);
            r.standby_request = 1'b1;
        end else begin
            if (ev.chg_ind)
                target = ST_CHARGING;
            else if (ev.cable_in && ev.gauge_percent >= FULL_PERCENT)
                target = ST_FULL;
            else if (ev.critical_lockout)
                target = ST_CRITICAL;
            else if (ev.low_power_active)
                target = ST_LOW_POWER;
            else if (ev.batt_pct <= first_pct)
                target = ST_WARNING;
            else
                target = ST_GOOD;
            case (ui_now)
                ST_GOOD:
                    go = target inside {ST_WARNING, ST_LOW_POWER, ST_CRITICAL,
                                        ST_CHARGING, ST_FULL};
                ST_WARNING:
                    go = target inside {ST_GOOD, ST_WARNING, ST_LOW_POWER, ST_CHARGING};
                ST_LOW_POWER:
                    go = target inside {ST_WARNING, ST_CRITICAL, ST_CHARGING};
                ST_CRITICAL:
                    go = target inside {ST_LOW_POWER, ST_CHARGING};
                ST_CHARGING:
                    go = target inside {ST_GOOD, ST_WARNING, ST_LOW_POWER, ST_CRITICAL,
                                        ST_FULL, ST_SHUTDOWN_CHG};
                ST_FULL:
                    go = target inside {ST_GOOD, ST_WARNING, ST_LOW_POWER, ST_CRITICAL,
                                        ST_SHUTDOWN_CHG};
                default:
                    go = 1'b0;
            endcase
        end
        if (go) begin
            if (ui_now != target) begin
                case (ui_now) inside
                    ST_WARNING, ST_CHARGING, ST_FULL: r.exit_action = EXIT_DISMISS_MODAL;
                    ST_LOW_POWER:                     r.exit_action = EXIT_LOW_POWER;
                    ST_CRITICAL:                      r.exit_action = EXIT_CRITICAL;
                    default:                          r.exit_action = EXIT_NONE;
                endcase
                if (ui_now == ST_WARNING)
                    warn_idx = NO_WARNING;
                ui_now = target;
            end
            r.accepted = 1'b1;
            case (target)
                ST_LOW_POWER:    r.enter_action = ENTER_LOW_POWER;
                ST_CRITICAL:     r.enter_action = ENTER_CRITICAL;
                ST_CHARGING:     r.enter_action = ENTER_PLUGGED;
                ST_FULL:         r.enter_action = ENTER_FULL;
                ST_SHUTDOWN_CHG: r.enter_action = ENTER_SHUTDOWN;
                default:         r.enter_action = ENTER_NONE;
            endcase
            case (target) inside
                ST_WARNING:
                begin
                    if (warn_idx == NO_WARNING && ev.batt_pct <= first_pct) begin
                        warn_idx = LEVEL_FIRST;
                        fresh    = 1'b1;
                    end
                    if (warn_idx == LEVEL_FIRST && ev.batt_pct <= second_pct) begin
                        warn_idx = LEVEL_SECOND;
                        fresh    = 1'b1;
                    end
                    // skip the first point when the second is already close
                    if (fresh && warn_idx == LEVEL_FIRST &&
                        {1'b0, ev.hours_left} < {1'b0, second_hours} + {1'b0, headroom})
                        fresh = 1'b0;
                    if (fresh) begin
                        r.show_warning    = 1'b1;
                        r.warning_level   = warn_idx[0];
                        r.warning_percent = ev.batt_pct;
                        r.vibrate         = !ev.dnd_active;
                    end
                end
                ST_CRITICAL, ST_CHARGING:
                    r.vibrate = !ev.dnd_active;
                default:
                    ;
            endcase
        end
        r.ui_state = ui_now;
        return r;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int got_val);
        if (exp_val != got_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            first_pct    = RST_FIRST_PCT;
            second_pct   = RST_SECOND_PCT;
            second_hours = RST_SECOND_HOURS;
            headroom     = RST_HEADROOM;
            ui_now       = ST_GOOD;
            warn_idx     = NO_WARNING;
            error_count  = 0;
            alert_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FIRST_PCT:    first_pct    = cfg_data[PCT_W-1:0];
                    CFG_SECOND_PCT:   second_pct   = cfg_data[PCT_W-1:0];
                    CFG_SECOND_HOURS: second_hours = cfg_data[HOURS_W-1:0];
                    CFG_HEADROOM:     headroom     = cfg_data[HOURS_W-1:0];
                    default:          ;
                endcase
            end
            if (evt_valid && !evt_stall)
                alert_q.push_back(next_alert(evt));
            if (res_valid && !res_stall) begin
                if (alert_q.size() == 0) begin
                    $error("result word with no event pending: ui_state %0d", ui_state);
                    error_count++;
                end else begin
                    want = alert_q.pop_front();
                    check_field("ui_state", want.ui_state, ui_state);
                    check_field("accepted", want.accepted, accepted);
                    check_field("exit_action", want.exit_action, exit_action);
                    check_field("enter_action", want.enter_action, enter_action);
                    check_field("show_warning", want.show_warning, show_warning);
                    check_field("warning_level", want.warning_level, warning_level);
                    check_field("warning_percent", want.warning_percent, warning_percent);
                    check_field("vibrate", want.vibrate, vibrate);
                    check_field("standby_request", want.standby_request, standby_request);
                end
            end
        end
        pending = alert_q.size();
    end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// Battery alert testbench
// Drives charge events and shutdown requests into the battery alert unit in
// random bursts while the result side stalls on its own pattern. A directed
// sequence walks the transition table and the warning rules, then random
// events run under several threshold settings, extremes included, and a final
// sequence enters shutdown charging. The checker beside the unit predicts and
// compares every result word; this module only makes stimulus and reports.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bas_pkg::*;
    import bas_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_EVENTS = 235;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_TOGGLE, STALL_HEAVY} stall_mode_e;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  evt_valid = 1'b0;
    logic                  evt_stall;
    evt_t                  evt_word = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    logic [2:0]            ui_state;
    logic                  accepted;
    logic [1:0]            exit_action;
    logic [2:0]            enter_action;
    logic                  show_warning;
    logic                  warning_level;
    logic [PCT_W-1:0]      warning_percent;
    logic                  vibrate;
    logic                  standby_request;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    errors;
    int                    pending;

    logic [PCT_W-1:0]      fw_pct = RST_FIRST_PCT;
    logic [PCT_W-1:0]      sw_pct = RST_SECOND_PCT;
    logic [HOURS_W-1:0]    sp_hours = RST_SECOND_HOURS;
    logic [HOURS_W-1:0]    head_hours = RST_HEADROOM;
    logic                  last_charging = 1'b0;
    stall_mode_e           stall_mode = STALL_NONE;
    int                    stall_left = 0;
    int                    cycles = 0;
    int                    phase;

    battery_alert_state_machine_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .evt_valid        (evt_valid),
        .evt_stall        (evt_stall),
        .req_type         (evt_word.req_type),
        .chg_ind          (evt_word.chg_ind),
        .cable_in         (evt_word.cable_in),
        .gauge_percent    (evt_word.gauge_percent),
        .batt_pct         (evt_word.batt_pct),
        .critical_lockout (evt_word.critical_lockout),
        .low_power_active (evt_word.low_power_active),
        .hours_left       (evt_word.hours_left),
        .dnd_active       (evt_word.dnd_active),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .ui_state         (ui_state),
        .accepted         (accepted),
        .exit_action      (exit_action),
        .enter_action     (enter_action),
        .show_warning     (show_warning),
        .warning_level    (warning_level),
        .warning_percent  (warning_percent),
        .vibrate          (vibrate),
        .standby_request  (standby_request),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    battery_alert_checker alert_chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .evt_valid        (evt_valid),
        .evt_stall        (evt_stall),
        .evt              (evt_word),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .ui_state         (ui_state),
        .accepted         (accepted),
        .exit_action      (exit_action),
        .enter_action     (enter_action),
        .show_warning     (show_warning),
        .warning_level    (warning_level),
        .warning_percent  (warning_percent),
        .vibrate          (vibrate),
        .standby_request  (standby_request),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .error_count      (errors),
        .pending          (pending)
    );

    always #2 clk = ~clk;

    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode = stall_mode_e'($urandom_range(3, 0));
            stall_left = $urandom_range(200, 20);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:   res_stall = 1'b0;
            STALL_RANDOM: res_stall = ($urandom_range(2, 0) == 0);
            STALL_TOGGLE: res_stall = ~res_stall;
            default:      res_stall = ($urandom_range(9, 0) < 7);
        endcase
    end

    function automatic evt_t mk(logic req, int chg, int plug, int gauge, int pct,
                                int crit, int lp, int hours, int dnd);
        evt_t e;
        e.req_type         = req;
        e.chg_ind          = 1'(chg);
        e.cable_in         = 1'(plug);
        e.gauge_percent    = PCT_W'(gauge);
        e.batt_pct         = PCT_W'(pct);
        e.critical_lockout = 1'(crit);
        e.low_power_active = 1'(lp);
        e.hours_left       = HOURS_W'(hours);
        e.dnd_active       = 1'(dnd);
        return e;
    endfunction

    // keep shutdown requests away from charging so the run is not parked early
    function automatic evt_t make_event();
        evt_t e;
        e.req_type = (!last_charging && $urandom_range(11, 0) == 0) ? REQ_SHUTDOWN : REQ_EVENT;
        e.chg_ind = ($urandom_range(5, 0) == 0);
        e.cable_in = 1'($urandom_range(1, 0));
        if ($urandom_range(1, 0) == 0)
            e.gauge_percent = PCT_W'($urandom_range(127, 96));
        else
            e.gauge_percent = PCT_W'($urandom_range(127, 0));
        case ($urandom_range(3, 0))
            0:       e.batt_pct = fw_pct + PCT_W'($urandom_range(6, 0)) - PCT_W'(3);
            1:       e.batt_pct = sw_pct + PCT_W'($urandom_range(6, 0)) - PCT_W'(3);
            2:       e.batt_pct = PCT_W'($urandom_range(30, 0));
            default: e.batt_pct = PCT_W'($urandom_range(127, 0));
        endcase
        e.critical_lockout = ($urandom_range(6, 0) == 0);
        e.low_power_active = ($urandom_range(5, 0) == 0);
        if ($urandom_range(1, 0) == 0)
            e.hours_left = sp_hours + head_hours + HOURS_W'($urandom_range(6, 0))
                           - HOURS_W'(3);
        else
            e.hours_left = HOURS_W'($urandom_range(255, 0));
        e.dnd_active = 1'($urandom_range(1, 0));
        return e;
    endfunction

    task automatic send_event(input evt_t w);
        @(negedge clk);
        evt_word  = w;
        evt_valid = 1'b1;
        if (w.req_type == REQ_EVENT)
            last_charging = w.chg_ind;
        do @(posedge clk); while (evt_stall);
    endtask

    task automatic rest(input int n);
        logic [31:0] noise;
        repeat (n) begin
            @(negedge clk);
            noise     = $urandom;
            evt_valid = 1'b0;
            evt_word  = noise[$bits(evt_t)-1:0];
        end
    endtask

    task automatic drain();
        rest(1);
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_data  = CFG_DATA_W'($urandom);
    endtask

    task automatic set_thresholds(input logic [7:0] first, input logic [7:0] second,
                                  input logic [7:0] hours, input logic [7:0] room);
        write_reg(CFG_FIRST_PCT, first);
        write_reg(CFG_SECOND_PCT, second);
        write_reg(CFG_SECOND_HOURS, hours);
        write_reg(CFG_HEADROOM, room);
        fw_pct     = first[PCT_W-1:0];
        sw_pct     = second[PCT_W-1:0];
        sp_hours   = hours;
        head_hours = room;
    endtask

    task automatic run_random(input int count);
        int burst;
        int n;
        burst = 0;
        for (n = 0; n < count; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(40, 1);
                rest(($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1));
            end
            burst--;
            send_event(make_event());
        end
    endtask

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // walk the table and the warning rules on reset thresholds
        send_event(mk(REQ_EVENT,    0, 0,  50,  50, 0, 0, 100, 0));
        send_event(mk(REQ_SHUTDOWN, 0, 0,   0,   0, 0, 0,   0, 0));
        send_event(mk(REQ_EVENT,    0, 0,  20,  20, 0, 0,  15, 0));
        send_event(mk(REQ_EVENT,    0, 0,  13,  13, 0, 0,   0, 1));
        send_event(mk(REQ_EVENT,    0, 1,  10,  10, 0, 0,  40, 0));
        send_event(mk(REQ_EVENT,    0, 0,  60,  60, 0, 0, 200, 0));
        send_event(mk(REQ_EVENT,    0, 0,  13,  13, 0, 0,   0, 0));
        send_event(mk(REQ_EVENT,    0, 0,  13,  13, 0, 1,   0, 0));
        send_event(mk(REQ_EVENT,    0, 0,   5,   5, 1, 1,   0, 0));
        send_event(mk(REQ_EVENT,    0, 0,   5,   5, 1, 0,   0, 0));
        send_event(mk(REQ_EVENT,    0, 0,   5,   5, 0, 1,   0, 1));
        send_event(mk(REQ_EVENT,    0, 0,  18,  18, 0, 0,  14, 0));
        send_event(mk(REQ_EVENT,    0, 0,  16,  16, 0, 0, 200, 0));
        send_event(mk(REQ_EVENT,    0, 0, 100, 100, 0, 0, 255, 0));
        send_event(mk(REQ_EVENT,    0, 1, 100, 100, 0, 0, 255, 0));
        send_event(mk(REQ_EVENT,    1, 1, 100, 100, 0, 0, 255, 0));
        send_event(mk(REQ_EVENT,    0, 0,  99,  99, 0, 0, 255, 0));
        send_event(mk(REQ_EVENT,    1, 0,   0,   0, 0, 0,   0, 0));
        send_event(mk(REQ_EVENT,    0, 1, 127, 127, 0, 0, 255, 1));
        send_event(mk(REQ_EVENT,    0, 0, 127, 127, 1, 0, 255, 1));
        send_event(mk(REQ_EVENT,    1, 1, 127, 127, 1, 1, 255, 1));
        send_event(mk(REQ_EVENT,    0, 0,   0,   0, 0, 0, 255, 0));
        send_event(mk(REQ_SHUTDOWN, 0, 0,   0,   0, 0, 0,   0, 0));
        send_event(mk(REQ_EVENT,    0, 0,  21,  21, 0, 0,   0, 0));
        send_event(mk(REQ_EVENT,    0, 1,  99, 127, 0, 0,   0, 0));
        drain();

        for (phase = 0; phase < 7; phase++) begin
            case (phase)
                0: ;
                1: set_thresholds(8'd0, 8'd0, 8'd0, 8'd0);
                2: set_thresholds(8'hFF, 8'hFF, 8'hFF, 8'hFF);
                3: set_thresholds(8'd100, 8'd100, 8'd255, 8'd0);
                4: set_thresholds(8'd30, 8'd10, 8'd20, 8'd5);
                5: set_thresholds(8'($urandom_range(100, 10)), 8'($urandom_range(40, 0)),
                                  8'($urandom_range(48, 0)), 8'($urandom_range(12, 0)));
                default: set_thresholds(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                                        8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
            endcase
            run_random(PHASE_EVENTS);
            drain();
        end

        // enter shutdown charging last: only reset leaves it
        send_event(mk(REQ_EVENT,    1, 1,  50,  50, 0, 0,  30, 0));
        send_event(mk(REQ_SHUTDOWN, 1, 1,  50,  50, 0, 0,  30, 0));
        send_event(mk(REQ_EVENT,    0, 0,  10,  10, 0, 0,  30, 0));
        send_event(mk(REQ_EVENT,    0, 0,  50,  50, 1, 0,  30, 0));
        send_event(mk(REQ_SHUTDOWN, 0, 0,   0,   0, 0, 0,   0, 0));
        run_random(8);
        drain();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/bas_pkg.sv
rtl/bas_cfg_regs.sv
rtl/bas_core.sv
rtl/battery_alert_state_machine_unit.sv
verif/battery_alert_checker.sv
verif/testbench.sv
